// ===== sv/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants
// field widths, request codes, register indexes and the pipeline control word
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int COORD_W   = 12;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 13;
  localparam int DST_MAX   = 4096;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               is_comp;
    logic               oor;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   rgb;
  } ctl_t;

endpackage

// ===== sv/brr_req_if.sv =====
// ----------------------------------------------------------------------------
// brr_req_if: request channel
// load or compute item with valid/ready handshake
// ----------------------------------------------------------------------------
interface brr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [brr_pkg::COORD_W-1:0] coord_x;
  logic [brr_pkg::COORD_W-1:0] coord_y;
  logic [brr_pkg::CH_W-1:0]  in_red;
  logic [brr_pkg::CH_W-1:0]  in_green;
  logic [brr_pkg::CH_W-1:0]  in_blue;

  modport source (output valid, req_type, coord_x, coord_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, req_type, coord_x, coord_y, in_red, in_green, in_blue,
                output ready);
endinterface

// ===== sv/brr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// brr_rsp_if: result channel
// interpolated pixel with valid/ready handshake
// ----------------------------------------------------------------------------
interface brr_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [brr_pkg::CH_W-1:0] out_red;
  logic [brr_pkg::CH_W-1:0] out_green;
  logic [brr_pkg::CH_W-1:0] out_blue;
  logic                     out_of_range;

  modport source (output valid, out_red, out_green, out_blue, out_of_range, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_of_range, output ready);
endinterface

// ===== sv/brr_ram.sv =====
// ----------------------------------------------------------------------------
// brr_ram: generic memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module brr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/brr_cfg.sv =====
// ----------------------------------------------------------------------------
// brr_cfg: configuration registers
// apb register file with saturation of written sizes
// ----------------------------------------------------------------------------
module brr_cfg #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brr_pkg::APB_AW-1:0]     paddr,
  input  logic [brr_pkg::APB_DW-1:0]     pwdata,
  output logic [brr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output logic [$clog2(MAX_SRC_WIDTH+1)-1:0]  src_width,
  output logic [$clog2(MAX_SRC_HEIGHT+1)-1:0] src_height,
  output logic [brr_pkg::DST_CFG_W-1:0]  dst_width,
  output logic [brr_pkg::DST_CFG_W-1:0]  dst_height
);

  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int RST_W = (MAX_SRC_WIDTH < 256) ? MAX_SRC_WIDTH : 256;
  localparam int RST_H = (MAX_SRC_HEIGHT < 256) ? MAX_SRC_HEIGHT : 256;

  function automatic logic [31:0] sat(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) r = 32'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  logic        wr;
  logic [31:0] sw_v;
  logic [31:0] sh_v;
  logic [31:0] dw_v;
  logic [31:0] dh_v;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign sw_v = sat(32'(pwdata[brr_pkg::SRC_CFG_W-1:0]), 32'(MAX_SRC_WIDTH));
  assign sh_v = sat(32'(pwdata[brr_pkg::SRC_CFG_W-1:0]), 32'(MAX_SRC_HEIGHT));
  assign dw_v = sat(32'(pwdata[brr_pkg::DST_CFG_W-1:0]), 32'(brr_pkg::DST_MAX));
  assign dh_v = dw_v;
  
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SWW'(RST_W);
      src_height <= SHW'(RST_H);
      dst_width  <= brr_pkg::DST_CFG_W'(256);
      dst_height <= brr_pkg::DST_CFG_W'(256);
    end else if (wr) begin
      unique case (paddr[3:2])
        brr_pkg::REG_SRC_WIDTH:  src_width  <= sw_v[SWW-1:0];
        brr_pkg::REG_SRC_HEIGHT: src_height <= sh_v[SHW-1:0];
        brr_pkg::REG_DST_WIDTH:  dst_width  <= dw_v[brr_pkg::DST_CFG_W-1:0];
        brr_pkg::REG_DST_HEIGHT: dst_height <= dh_v[brr_pkg::DST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      brr_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width);
      brr_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height);
      brr_pkg::REG_DST_WIDTH:  prdata = 32'(dst_width);
      brr_pkg::REG_DST_HEIGHT: prdata = 32'(dst_height);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== sv/brr_axis.sv =====
// ----------------------------------------------------------------------------
// brr_axis: coordinate mapping along one axis
// multiply, one restoring divide step per stage, then clamp to the frame
// ----------------------------------------------------------------------------
module brr_axis #(
  parameter int SRC_MAX   = 256,
  parameter int IW        = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [brr_pkg::COORD_W-1:0]     d,
  input  logic [$clog2(SRC_MAX+1)-1:0]    ssz,
  input  logic [brr_pkg::DST_CFG_W-1:0]   dsz,
  output logic [IW-1:0]                   base,
  output logic [IW-1:0]                   next,
  output logic [FRAC_BITS-1:0]            frac
);

  localparam int SZW = $clog2(SRC_MAX + 1);
  localparam int NW  = brr_pkg::COORD_W + SZW;
  localparam int DW  = brr_pkg::DST_CFG_W;
  localparam int QW  = IW + FRAC_BITS;
  localparam int N   = QW;

  logic [NW-1:0]  num0;
  logic [SZW-1:0] ssz0;
  logic [DW-1:0]  dsz0;
  logic [NW-1:0]  num_sh;

  logic [DW-1:0]  rem_q  [1:N];
  logic [IW-1:0]  nlo_q  [1:N];
  logic [QW-1:0]  quo_q  [1:N];
  logic [DW-1:0]  dsz_q  [1:N];
  logic [SZW-1:0] ssz_q  [1:N];

  // product of destination coordinate and source size
  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= NW'(d) * NW'(ssz);
      ssz0 <= ssz;
      dsz0 <= dsz;
    end
  end

  // quotient fits in IW bits, so the top of the product starts as remainder
  assign num_sh = num0 >> IW;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [DW-1:0]  r_in;
    logic [IW-1:0]  n_in;
    logic [QW-1:0]  q_in;
    logic [DW-1:0]  d_in;
    logic [SZW-1:0] s_in;
    logic [DW:0]    t;
    logic           ge;
    logic [DW:0]    diff;

    if (k == 0) begin : g_first
      assign r_in = num_sh[DW-1:0];
      assign n_in = num0[IW-1:0];
      assign q_in = '0;
      assign d_in = dsz0;
      assign s_in = ssz0;
    end else begin : g_rest
      assign r_in = rem_q[k];
      assign n_in = nlo_q[k];
      assign q_in = quo_q[k];
      assign d_in = dsz_q[k];
      assign s_in = ssz_q[k];
    end

    assign t    = {r_in, n_in[IW-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nlo_q[k+1] <= n_in << 1;
        quo_q[k+1] <= {q_in[QW-2:0], ge};
        dsz_q[k+1] <= d_in;
        ssz_q[k+1] <= s_in;
      end
    end
  end

  logic [31:0] b32;
  logic [31:0] s32;
  logic [31:0] bc32;
  logic [31:0] nx32;

  assign b32  = 32'(quo_q[N][QW-1:FRAC_BITS]);
  assign s32  = 32'(ssz_q[N]);
  assign bc32 = (b32 >= s32) ? s32 - 32'd1 : b32;
  assign nx32 = (bc32 + 32'd1 < s32) ? bc32 + 32'd1 : bc32;

  always_ff @(posedge clk) begin
    if (en) begin
      base <= bc32[IW-1:0];
      next <= nx32[IW-1:0];
      frac <= quo_q[N][FRAC_BITS-1:0];
    end
  end

endmodule

// ===== sv/brr_blend.sv =====
// ----------------------------------------------------------------------------
// brr_blend: bilinear weighting
// weight products, per-texel channel products, and the final sum
// ----------------------------------------------------------------------------
module brr_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [FRAC_BITS-1:0]       fx,
  input  logic [FRAC_BITS-1:0]       fy,
  input  logic [brr_pkg::PIX_W-1:0]  p11,
  input  logic [brr_pkg::PIX_W-1:0]  p12,
  input  logic [brr_pkg::PIX_W-1:0]  p21,
  input  logic [brr_pkg::PIX_W-1:0]  p22,
  output logic [brr_pkg::CH_W-1:0]   red,
  output logic [brr_pkg::CH_W-1:0]   green,
  output logic [brr_pkg::CH_W-1:0]   blue
);

  localparam int F  = FRAC_BITS;
  localparam int WW = 2 * F + 1;
  localparam int PW = WW + brr_pkg::CH_W;
  localparam int SW = PW + 2;
  localparam int CW = brr_pkg::CH_W;

  logic [F:0]    one;
  logic [F:0]    omx;
  logic [F:0]    omy;
  logic [WW-1:0] wa [0:3];
  logic [WW-1:0] wb [0:3];
  logic [PW-1:0] prod [0:2][0:3];
  logic [SW-1:0] acc [0:2];
  logic [brr_pkg::PIX_W-1:0] pix [0:3];

  assign one = {1'b1, {F{1'b0}}};
  assign omx = one - {1'b0, fx};
  assign omy = one - {1'b0, fy};
  assign pix[0] = p11;
  assign pix[1] = p12;
  assign pix[2] = p21;
  assign pix[3] = p22;

  always_ff @(posedge clk) begin
    if (en) begin
      wa[0] <= WW'(omx) * WW'(omy);
      wa[1] <= WW'(fx) * WW'(omy);
      wa[2] <= WW'(omx) * WW'(fy);
      wa[3] <= WW'(fx) * WW'(fy);
      wb    <= wa;
    end
  end

  // channel c sits at bits [PIX_W-1-CW*c -: CW], red first
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod[c][k] <= PW'(pix[k][brr_pkg::PIX_W-1-CW*c -: CW]) * PW'(wb[k]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2]) + SW'(prod[c][3]);
    end
  end

  assign red   = acc[0][2*F +: CW];
  assign green = acc[1][2*F +: CW];
  assign blue  = acc[2][2*F +: CW];

endmodule

// ===== sv/bilinear_rgb_resampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_rgb_resampler: bilinear rgb888 frame resampler
// source frame store with a fully pipelined mapping and blend datapath
// ----------------------------------------------------------------------------
// req channel: a load item (req_type 0) writes one source pixel into the
//   frame store and gives no result; a compute item (req_type 1) names a
//   destination pixel and gives exactly one item on the rsp channel
// rsp channel: blended rgb, or zero rgb with out_of_range set when the
//   destination coordinate lies outside dst_width/dst_height
// apb port: src_width, src_height, dst_width, dst_height at 0x0..0xc, to be
//   written only while the pipeline is empty; the block does not enforce this
// throughput: one item per cycle while the output is not stalled; the frame store
//   is kept in four copies so the four texels of a pixel are read in the same cycle
// path: from accept to rsp.valid an item passes the axis product, the one-bit-per-
//   stage divider, clamp, address, frame store read, products and output registers
// reset: clears valid bits and loads the default sizes; the frame store is
//   not cleared and must be loaded before it is read
// stall: the whole pipeline holds while the output register is full and
//   rsp.ready is low; req.ready follows, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module bilinear_rgb_resampler #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  brr_req_if.sink                     req,
  brr_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brr_pkg::APB_AW-1:0]  paddr,
  input  logic [brr_pkg::APB_DW-1:0]  pwdata,
  output logic [brr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int MAX_SRC = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int IW      = $clog2(MAX_SRC);
  localparam int SWW     = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW     = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  // axis latency: product stage, divide steps, clamp stage
  localparam int L       = IW + FRAC_BITS + 2;
  localparam int CW      = brr_pkg::CH_W;

  logic [SWW-1:0]                src_width;
  logic [SHW-1:0]                src_height;
  logic [brr_pkg::DST_CFG_W-1:0] dst_width;
  logic [brr_pkg::DST_CFG_W-1:0] dst_height;

  brr_cfg #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_width  (src_width),
    .src_height (src_height),
    .dst_width  (dst_width),
    .dst_height (dst_height)
  );

  // global advance: everything moves unless a result waits and is not taken
  logic out_valid;
  logic en;

  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // control word at entry
  brr_pkg::ctl_t ctl_in;

  always_comb begin
    ctl_in.valid   = req.valid;
    ctl_in.is_comp = (req.req_type == brr_pkg::REQ_COMPUTE);
    ctl_in.oor     = (brr_pkg::DST_CFG_W'(req.coord_x) >= dst_width) ||
                     (brr_pkg::DST_CFG_W'(req.coord_y) >= dst_height);
    ctl_in.x       = req.coord_x;
    ctl_in.y       = req.coord_y;
    ctl_in.rgb     = {req.in_red, req.in_green, req.in_blue};
  end

  // control line alongside the axis pipelines
  brr_pkg::ctl_t ctl [0:L-1];
  brr_pkg::ctl_t ctl_a;
  brr_pkg::ctl_t ctl_b;
  brr_pkg::ctl_t ctl_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) begin
        ctl[i].valid <= 1'b0;
      end
      ctl_a.valid <= 1'b0;
      ctl_b.valid <= 1'b0;
      ctl_c.valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < L; i++) begin
        ctl[i] <= ctl[i-1];
      end
      ctl_a <= ctl[L-1];
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  // source position along each axis
  logic [IW-1:0]        sx;
  logic [IW-1:0]        nx;
  logic [IW-1:0]        sy;
  logic [IW-1:0]        ny;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;

  brr_axis #(
    .SRC_MAX   (MAX_SRC_WIDTH),
    .IW        (IW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .clk  (clk),
    .en   (en),
    .d    (req.coord_x),
    .ssz  (src_width),
    .dsz  (dst_width),
    .base (sx),
    .next (nx),
    .frac (fx)
  );

  brr_axis #(
    .SRC_MAX   (MAX_SRC_HEIGHT),
    .IW        (IW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .clk  (clk),
    .en   (en),
    .d    (req.coord_y),
    .ssz  (src_height),
    .dsz  (dst_height),
    .base (sy),
    .next (ny),
    .frac (fy)
  );

  // texel addresses, registered alongside the weight products
  logic [AW-1:0] addr_a [0:3];
  logic [31:0]   row_s;
  logic [31:0]   row_n;

  assign row_s = 32'(sy) * 32'(MAX_SRC_WIDTH);
  assign row_n = 32'(ny) * 32'(MAX_SRC_WIDTH);

  always_ff @(posedge clk) begin
    if (en) begin
      addr_a[0] <= AW'(row_s + 32'(sx));
      addr_a[1] <= AW'(row_s + 32'(nx));
      addr_a[2] <= AW'(row_n + 32'(sx));
      addr_a[3] <= AW'(row_n + 32'(nx));
    end
  end

  // loads write in order at the read stage, so a compute sees every earlier load
  logic [31:0]   ld_addr32;
  logic [AW-1:0] ld_addr;
  logic          ld_ok;
  logic          we;

  assign ld_addr32 = 32'(ctl_a.y) * 32'(MAX_SRC_WIDTH) + 32'(ctl_a.x);
  assign ld_addr   = ld_addr32[AW-1:0];
  assign ld_ok     = (32'(ctl_a.x) < 32'(MAX_SRC_WIDTH)) &&
                     (32'(ctl_a.y) < 32'(MAX_SRC_HEIGHT));
  assign we        = en && ctl_a.valid && !ctl_a.is_comp && ld_ok;

  // four copies of the frame store, one per texel of the 2x2 neighborhood
  logic [brr_pkg::PIX_W-1:0] tex [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_store
    brr_ram #(
      .WIDTH (brr_pkg::PIX_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (ld_addr),
      .wdata (ctl_a.rgb),
      .re    (en),
      .raddr (addr_a[k]),
      .rdata (tex[k])
    );
  end

  // weights, channel products and sum
  logic [CW-1:0] blend_r;
  logic [CW-1:0] blend_g;
  logic [CW-1:0] blend_b;

  brr_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .en    (en),
    .fx    (fx),
    .fy    (fy),
    .p11   (tex[0]),
    .p12   (tex[1]),
    .p21   (tex[2]),
    .p22   (tex[3]),
    .red   (blend_r),
    .green (blend_g),
    .blue  (blend_b)
  );

  // output register; only compute items produce a result
  logic [CW-1:0] out_r;
  logic [CW-1:0] out_g;
  logic [CW-1:0] out_b;
  logic          out_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_c.valid && ctl_c.is_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r   <= ctl_c.oor ? '0 : blend_r;
      out_g   <= ctl_c.oor ? '0 : blend_g;
      out_b   <= ctl_c.oor ? '0 : blend_b;
      out_oor <= ctl_c.oor;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_red      = out_r;
  assign rsp.out_green    = out_g;
  assign rsp.out_blue     = out_b;
  assign rsp.out_of_range = out_oor;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: bilinear rgb888 resampler testbench
// loads source pixels and asks for destination pixels under several frame sizes;
// every result is checked against a typed value or an in-bench bilinear blend
// of the shadow frame, with random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_W     = 256;
  localparam int STORE_H     = 256;
  localparam int FRAC        = 16;
  localparam int TAIL_CYCLES = 50;
  localparam int STALL_LIMIT = 3000;  // cycles with no item accepted anywhere and no apb access
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 105;

  // idling styles
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       oor;
  } pix_res_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] rgb;
    logic        typed;   // expected value written in below
    logic [23:0] want_rgb;
    logic        want_oor;
  } dir_row_t;

  // default sizes are 256 everywhere, so frac is zero and a pixel maps to
  // its own source texel
  localparam int DIR_N = 20;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{brr_pkg::REQ_LOAD,    12'd0,    12'd0,    24'hff0080, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_LOAD,    12'd255,  12'd255,  24'h01fe7f, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_LOAD,    12'd255,  12'd0,    24'h123456, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_LOAD,    12'd0,    12'd255,  24'haa5500, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd0,    12'd0,    24'h0,      1'b1, 24'hff0080, 1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd255,  12'd255,  24'h0,      1'b1, 24'h01fe7f, 1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd255,  12'd0,    24'h0,      1'b1, 24'h123456, 1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd0,    12'd255,  24'h0,      1'b1, 24'haa5500, 1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd256,  12'd0,    24'h0,      1'b1, 24'h000000, 1'b1},
    '{brr_pkg::REQ_COMPUTE, 12'd0,    12'd256,  24'h0,      1'b1, 24'h000000, 1'b1},
    '{brr_pkg::REQ_COMPUTE, 12'd4095, 12'd4095, 24'h0,      1'b1, 24'h000000, 1'b1},
    // loads outside the store must not alias onto stored pixels
    '{brr_pkg::REQ_LOAD,    12'd256,  12'd0,    24'h000000, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_LOAD,    12'd0,    12'd256,  24'hffffff, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_LOAD,    12'd4095, 12'd4095, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd0,    12'd0,    24'h0,      1'b1, 24'hff0080, 1'b0},
    '{brr_pkg::REQ_LOAD,    12'd128,  12'd64,   24'hffffff, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd128,  12'd64,   24'h0,      1'b1, 24'hffffff, 1'b0},
    '{brr_pkg::REQ_LOAD,    12'd17,   12'd200,  24'h000000, 1'b0, 24'h0,      1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd17,   12'd200,  24'h0,      1'b1, 24'h000000, 1'b0},
    '{brr_pkg::REQ_COMPUTE, 12'd4095, 12'd0,    24'h0,      1'b1, 24'h000000, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [brr_pkg::APB_AW-1:0] paddr = '0;
  logic [brr_pkg::APB_DW-1:0] pwdata = '0;
  logic [brr_pkg::APB_DW-1:0] prdata;
  logic pready;

  brr_req_if req_ch ();
  brr_rsp_if rsp_ch ();

  bilinear_rgb_resampler u_top (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow frame and sizes
  logic [23:0] frame_mem [0:STORE_W*STORE_H-1];
  bit          frame_loaded [0:STORE_W*STORE_H-1];
  int unsigned cfg_sw = 256, cfg_sh = 256, cfg_dw = 256, cfg_dh = 256;

  pix_res_t pixels_due [$];
  int errors = 0;
  int idle_mode = IDLE_NONE;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  int n_loads = 0, n_ignored = 0, n_pixels = 0, n_oor = 0, n_checked = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = brr_pkg::REQ_LOAD;
    req_ch.coord_x = '0;
    req_ch.coord_y = '0;
    req_ch.in_red = '0;
    req_ch.in_green = '0;
    req_ch.in_blue = '0;
    rsp_ch.ready = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // base texel, clamped neighbor and q0.16 fraction along one axis
  function automatic void map_axis(input int unsigned d, input int unsigned ssz,
                                   input int unsigned dsz, output int unsigned b,
                                   output int unsigned n, output longint unsigned f);
    longint unsigned num, q, rem;
    num = longint'(d) * ssz;
    q = num / dsz;
    rem = num - q * dsz;
    if (q >= ssz) q = ssz - 1;
    b = int'(q);
    n = (q + 1 < ssz) ? int'(q + 1) : int'(q);
    f = (rem << FRAC) / dsz;
  endfunction

  function automatic pix_res_t blend_pixel(logic [11:0] x, logic [11:0] y);
    int unsigned sx, nx, sy, ny;
    longint unsigned fx, fy, one, acc;
    longint unsigned w [4];
    logic [23:0] p [4];
    logic [7:0] ch [3];
    pix_res_t r;
    if (x >= cfg_dw || y >= cfg_dh) begin
      r = '{8'd0, 8'd0, 8'd0, 1'b1};
      return r;
    end
    map_axis(x, cfg_sw, cfg_dw, sx, nx, fx);
    map_axis(y, cfg_sh, cfg_dh, sy, ny, fy);
    one = 64'd1 << FRAC;
    w[0] = (one - fx) * (one - fy);
    w[1] = fx * (one - fy);
    w[2] = (one - fx) * fy;
    w[3] = fx * fy;
    p[0] = frame_mem[sy * STORE_W + sx];
    p[1] = frame_mem[sy * STORE_W + nx];
    p[2] = frame_mem[ny * STORE_W + sx];
    p[3] = frame_mem[ny * STORE_W + nx];
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++)
        acc += longint'(p[k][16 - 8 * c +: 8]) * w[k];
      ch[c] = 8'((acc >> (2 * FRAC)) & 64'hff);
    end
    r = '{ch[0], ch[1], ch[2], 1'b0};
    return r;
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
      return $urandom_range(99) < (idle_mode == IDLE_SEND ? 69 : 6);
    return 1'b0;
  endfunction

  // offer one item until accepted; the shadow is updated at acceptance
  task automatic push_request(logic kind, logic [11:0] x, logic [11:0] y,
                              logic [23:0] rgb, bit typed, pix_res_t want);
    bit taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (sender_idles()) begin
        req_ch.valid = 1'b0;
      end else begin
        req_ch.valid = 1'b1;
        req_ch.req_type = kind;
        req_ch.coord_x = x;
        req_ch.coord_y = y;
        {req_ch.in_red, req_ch.in_green, req_ch.in_blue} = rgb;
      end
      @(posedge clk);
      if (req_ch.valid && req_ch.ready) begin
        taken = 1'b1;
        if (kind == brr_pkg::REQ_LOAD) begin
          if (x < STORE_W && y < STORE_H) begin
            frame_mem[y * STORE_W + x] = rgb;
            frame_loaded[y * STORE_W + x] = 1'b1;
            n_loads++;
          end else begin
            n_ignored++;
          end
        end else begin
          pixels_due.push_back(typed ? want : blend_pixel(x, y));
          if (x >= cfg_dw || y >= cfg_dh) n_oor++;
          else n_pixels++;
        end
      end
    end
  endtask

  // a pixel may only be asked for once all four of its texels were loaded
  task automatic fill_texels(logic [11:0] x, logic [11:0] y);
    int unsigned sx, nx, sy, ny;
    longint unsigned fx, fy;
    int unsigned tx [4], ty [4];
    if (x >= cfg_dw || y >= cfg_dh) return;
    map_axis(x, cfg_sw, cfg_dw, sx, nx, fx);
    map_axis(y, cfg_sh, cfg_dh, sy, ny, fy);
    tx = '{sx, nx, sx, nx};
    ty = '{sy, sy, ny, ny};
    for (int k = 0; k < 4; k++)
      if (!frame_loaded[ty[k] * STORE_W + tx[k]])
        push_request(brr_pkg::REQ_LOAD, 12'(tx[k]), 12'(ty[k]), 24'($urandom), 1'b0, '0);
  endtask

  task automatic ask_pixel(logic [11:0] x, logic [11:0] y);
    fill_texels(x, y);
    push_request(brr_pkg::REQ_COMPUTE, x, y, 24'($urandom), 1'b0, '0);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      brr_pkg::REG_SRC_WIDTH:  cfg_sw = clamp_size(val & 32'h1ff, STORE_W);
      brr_pkg::REG_SRC_HEIGHT: cfg_sh = clamp_size(val & 32'h1ff, STORE_H);
      brr_pkg::REG_DST_WIDTH:  cfg_dw = clamp_size(val & 32'h1fff, brr_pkg::DST_MAX);
      brr_pkg::REG_DST_HEIGHT: cfg_dh = clamp_size(val & 32'h1fff, brr_pkg::DST_MAX);
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // drain: every pixel back, then room for loads still in flight
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver side: random stalls, forced low while the hold-off runs
  always @(negedge clk) begin
    if (hold_off)
      rsp_ch.ready <= 1'b0;
    else if (idle_mode == IDLE_RECV)
      rsp_ch.ready <= ($urandom_range(99) >= 69);
    else if (idle_mode == IDLE_BOTH)
      rsp_ch.ready <= ($urandom_range(99) >= 6);
    else
      rsp_ch.ready <= 1'b1;
  end

  // result checker: oldest expectation first
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        pix_res_t want;
        want = pixels_due.pop_front();
        n_checked++;
        if (rsp_ch.out_red !== want.red)
          report_mismatch($sformatf("red %h want %h", rsp_ch.out_red, want.red));
        if (rsp_ch.out_green !== want.green)
          report_mismatch($sformatf("green %h want %h", rsp_ch.out_green, want.green));
        if (rsp_ch.out_blue !== want.blue)
          report_mismatch($sformatf("blue %h want %h", rsp_ch.out_blue, want.blue));
        if (rsp_ch.out_of_range !== want.oor)
          report_mismatch($sformatf("out_of_range %b want %b",
                                    rsp_ch.out_of_range, want.oor));
      end
    end
  end

  // watchdog: only stretches with no item moving on either channel and no apb access count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned raw [4];
    pix_res_t want;
    int pick;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at default sizes
    foreach (DIR_ROWS[i]) begin
      want = '{DIR_ROWS[i].want_rgb[23:16], DIR_ROWS[i].want_rgb[15:8],
               DIR_ROWS[i].want_rgb[7:0], DIR_ROWS[i].want_oor};
      if (DIR_ROWS[i].kind == brr_pkg::REQ_COMPUTE)
        fill_texels(DIR_ROWS[i].x, DIR_ROWS[i].y);
      push_request(DIR_ROWS[i].kind, DIR_ROWS[i].x, DIR_ROWS[i].y,
                   DIR_ROWS[i].rgb, DIR_ROWS[i].typed, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      // first phases hit the size extremes, including zero and too-large writes
      case (ph)
        0: raw = '{4, 4, 8, 8};
        1: raw = '{1, 1, 1, 1};
        2: raw = '{256, 256, 4096, 4096};
        3: raw = '{0, 0, 0, 0};
        4: raw = '{32'hffff_f1ff, 511, 32'hffff_ffff, 8191};
        5: raw = '{7, 3, 13, 29};
        default: raw = '{$urandom_range(1, 16), $urandom_range(1, 16),
                         $urandom_range(1, 64), $urandom_range(1, 64)};
      endcase
      reg_write(brr_pkg::REG_SRC_WIDTH, raw[0]);
      reg_write(brr_pkg::REG_SRC_HEIGHT, raw[1]);
      reg_write(brr_pkg::REG_DST_WIDTH, raw[2]);
      reg_write(brr_pkg::REG_DST_HEIGHT, raw[3]);
      idle_mode = ph % 4;

      // long output stall while the sender keeps offering pixels
      if (ph == 4)
        fork
          begin
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 65)
          ask_pixel(12'($urandom_range(cfg_dw - 1)), 12'($urandom_range(cfg_dh - 1)));
        else if (pick < 77)
          ask_pixel(12'($urandom), 12'($urandom));
        else if (pick < 93)
          push_request(brr_pkg::REQ_LOAD, 12'($urandom_range(cfg_sw - 1)),
                       12'($urandom_range(cfg_sh - 1)), 24'($urandom), 1'b0, '0);
        else
          push_request(brr_pkg::REQ_LOAD, 12'($urandom), 12'($urandom), 24'($urandom),
                       1'b0, '0);
      end
    end

    wait_drained();
    $display("tb_top: %0d pixels checked (%0d blended, %0d out of range), %0d loads",
             n_checked, n_pixels, n_oor, n_loads);
    $display("tb_top: %0d loads outside the store, %0d size settings, %0d mismatches",
             n_ignored, PHASES + 1, errors);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== bilinear_rgb_resampler.f =====
sv/brr_pkg.sv
sv/brr_req_if.sv
sv/brr_rsp_if.sv
sv/brr_ram.sv
sv/brr_cfg.sv
sv/brr_axis.sv
sv/brr_blend.sv
sv/bilinear_rgb_resampler.sv
bench/tb_top.sv
